>>> src/ptd_pkg.sv
// Package for the periodic task dispatcher: controller states, operation
// and result codes, slot entry layout. No dependencies.
`default_nettype none

package ptd_pkg;

	localparam int HANDLE_W = 8;
	localparam int TIME_W   = 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_LAST,
		ST_END
	} state_t;

	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_CREATE = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_FIRED  = 2'd1;
	localparam logic [1:0] KIND_IDLE   = 2'd2;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [TIME_W-1:0]   period;
		logic [TIME_W-1:0]   countdown;
	} entry_t;

endpackage

`default_nettype wire

>>> src/ptd_slot_mem.sv
// Slot table memory: one write port, one read port, registered read data.
// Depends on ptd_pkg for the entry layout.
`default_nettype none

module ptd_slot_mem
	import ptd_pkg::*;
#(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire entry_t        wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output entry_t             rd_data
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> src/periodic_task_dispatcher_unit.sv
// Periodic task dispatcher top level: slot walk controller around the slot
// table memory. Depends on ptd_pkg and ptd_slot_mem.
//
// Usage: drive opcode, task_handle, period and phase_offset with start high;
// the command transfers on a rising edge where start is high and busy is low.
// Results appear on result_kind/success/fired_handle/fired_slot/last, each
// valid for exactly one cycle while strobe is high; last marks the final
// result of a command. The receiver cannot stall, so nothing is held back.
// Create and unknown opcodes: one status result the cycle after transfer,
// busy never rises, so a new command may follow in the next cycle.
// Tick: the controller walks the appended slots, one memory read per cycle
// with the update written back in the following cycle; fired results
// trickle out during the walk, the final one in the cycle in which busy
// falls, and a tick that fires nothing gives one idle result there. A tick
// on an empty table gives its idle result at once like a create. Delete
// walks all MAX_TASKS slots and reports status at the end. The slot walk
// through the single read port sets the rate: busy stays high until the
// walk is over. Reset empties the table (valid bits and fill count are
// cleared at once, no memory sweep) and drops any command in progress.
`default_nettype none

module periodic_task_dispatcher_unit
	import ptd_pkg::*;
#(
	parameter int MAX_TASKS = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [1:0]          opcode,
	input  wire logic [HANDLE_W-1:0] task_handle,
	input  wire logic [TIME_W-1:0]   period,
	input  wire logic [TIME_W-1:0]   phase_offset,
	output logic                     strobe,
	output logic [1:0]               result_kind,
	output logic                     success,
	output logic [HANDLE_W-1:0]      fired_handle,
	output logic [2:0]               fired_slot,
	output logic                     last
);

	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int UW = $clog2(MAX_TASKS + 1);
	localparam logic [UW-1:0] LAST_SLOT = UW'(MAX_TASKS - 1);
	localparam logic [UW-1:0] FULL      = UW'(MAX_TASKS);

	state_t state_q, state_d;

	logic [IW-1:0]       idx_q;
	logic                is_tick_q;
	logic [HANDLE_W-1:0] key_q;
	logic                chk_s1;
	logic [IW-1:0]       slot_s1;
	logic                found_q;
	logic                pend_q;
	logic [HANDLE_W-1:0] pend_handle_q;
	logic [IW-1:0]       pend_slot_q;
	logic [MAX_TASKS-1:0] valid_q;
	logic [UW-1:0]       used_q;

	logic                strobe_q;
	logic [1:0]          kind_q;
	logic                ok_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [2:0]          slot_q;
	logic                last_q;

	logic                accept;
	logic                create_ok;
	logic                at_last;
	logic [UW-1:0]       last_idx;
	logic                slot_live;
	logic                fire;
	logic                del_hit;

	logic                emit;
	logic [1:0]          emit_kind;
	logic                emit_ok;
	logic [HANDLE_W-1:0] emit_handle;
	logic [2:0]          emit_slot;
	logic                emit_last;

	logic                rd_en;
	logic                wr_en;
	logic [IW-1:0]       wr_addr;
	entry_t              wr_data;
	entry_t              rd_data;

	ptd_slot_mem #(
		.DEPTH(MAX_TASKS),
		.AW   (IW)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(idx_q),
		.rd_data(rd_data)
	);

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && (state_q == ST_IDLE);
	assign create_ok = accept && (opcode == OP_CREATE) && (task_handle != '0)
		&& (used_q < FULL);
	assign last_idx  = is_tick_q ? (used_q - UW'(1)) : LAST_SLOT;
	assign at_last   = (UW'(idx_q) == last_idx);
	assign slot_live = valid_q[slot_s1];
	assign fire      = chk_s1 && is_tick_q && slot_live && (rd_data.countdown == '0);
	assign del_hit   = chk_s1 && !is_tick_q && !found_q
		&& (slot_live ? (rd_data.handle == key_q) : (key_q == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		rd_en       = 1'b0;
		wr_en       = 1'b0;
		wr_addr     = slot_s1;
		wr_data     = rd_data;
		emit        = 1'b0;
		emit_kind   = KIND_STATUS;
		emit_ok     = 1'b1;
		emit_handle = '0;
		emit_slot   = '0;
		emit_last   = 1'b1;

		if (chk_s1 && is_tick_q && slot_live) begin
			wr_en             = 1'b1;
			wr_data.countdown = fire ? (rd_data.period - TIME_W'(1))
				: (rd_data.countdown - TIME_W'(1));
		end
		if (fire && pend_q) begin
			emit        = 1'b1;
			emit_kind   = KIND_FIRED;
			emit_handle = pend_handle_q;
			emit_slot   = 3'(pend_slot_q);
			emit_last   = 1'b0;
		end

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (opcode == OP_TICK) begin
						if (used_q == '0) begin
							emit      = 1'b1;
							emit_kind = KIND_IDLE;
						end else begin
							state_d = ST_WALK;
						end
					end else if (opcode == OP_DELETE) begin
						state_d = ST_WALK;
					end else begin
						emit    = 1'b1;
						emit_ok = create_ok;
					end
				end
				if (create_ok) begin
					wr_en   = 1'b1;
					wr_addr = used_q[IW-1:0];
					wr_data = '{handle: task_handle, period: period,
						countdown: phase_offset};
				end
			end
			ST_WALK: begin
				rd_en = 1'b1;
				if (at_last) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = ST_END;
			end
			ST_END: begin
				emit    = 1'b1;
				state_d = ST_IDLE;
				if (!is_tick_q) begin
					emit_ok = found_q;
				end else if (pend_q) begin
					emit_kind   = KIND_FIRED;
					emit_handle = pend_handle_q;
					emit_slot   = 3'(pend_slot_q);
				end else begin
					emit_kind = KIND_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_s1   <= 1'b0;
			found_q  <= 1'b0;
			pend_q   <= 1'b0;
			valid_q  <= '0;
			used_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			chk_s1   <= (state_q == ST_WALK);
			strobe_q <= emit;
			if (accept) begin
				found_q <= 1'b0;
				pend_q  <= 1'b0;
			end
			if (fire) begin
				pend_q <= 1'b1;
			end
			if (del_hit) begin
				found_q          <= 1'b1;
				valid_q[slot_s1] <= 1'b0;
			end
			if (create_ok) begin
				valid_q[used_q[IW-1:0]] <= 1'b1;
				used_q                  <= used_q + UW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= idx_q;
		if (accept) begin
			idx_q     <= '0;
			is_tick_q <= (opcode == OP_TICK);
			key_q     <= task_handle;
		end else if (state_q == ST_WALK) begin
			idx_q <= idx_q + IW'(1);
		end
		if (fire) begin
			pend_handle_q <= rd_data.handle;
			pend_slot_q   <= slot_s1;
		end
		kind_q   <= emit_kind;
		ok_q     <= emit_ok;
		handle_q <= emit_handle;
		slot_q   <= emit_slot;
		last_q   <= emit_last;
	end

	assign strobe       = strobe_q;
	assign result_kind  = kind_q;
	assign success      = ok_q;
	assign fired_handle = handle_q;
	assign fired_slot   = slot_q;
	assign last         = last_q;

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Testbench for periodic_task_dispatcher_unit: a directed command table, then
// random commands in phases with differing idle gaps, checked against an in-bench slot table model.
// Depends on ptd_pkg and the RTL under src.
`default_nettype none

module tb_top
	import ptd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 8;
	localparam int STALL_LIMIT = 1000;
	localparam int PHASE_ITEMS = 39;
	localparam logic [1:0] OP_BAD = 2'd3;

	typedef struct packed {
		logic [1:0]          op;
		logic [HANDLE_W-1:0] handle;
		logic [TIME_W-1:0]   per;
		logic [TIME_W-1:0]   dly;
	} cmd_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic                ok;
		logic [HANDLE_W-1:0] handle;
		logic [2:0]          slot;
		logic                last;
	} outcome_t;

	typedef struct packed {
		cmd_t       cmd;
		logic       typed;
		logic [1:0] kind;
		logic       ok;
	} step_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [1:0]          opcode;
	logic [HANDLE_W-1:0] task_handle;
	logic [TIME_W-1:0]   period;
	logic [TIME_W-1:0]   phase_offset;
	logic                strobe;
	logic [1:0]          result_kind;
	logic                success;
	logic [HANDLE_W-1:0] fired_handle;
	logic [2:0]          fired_slot;
	logic                last;

	logic [HANDLE_W-1:0] slot_hnd [SLOTS] = '{default: '0};
	logic [TIME_W-1:0]   slot_per [SLOTS] = '{default: '0};
	logic [TIME_W-1:0]   slot_cnt [SLOTS] = '{default: '0};
	int                  slots_filled = 0;

	outcome_t pending_results[$];
	outcome_t want;
	step_t    plan [25];
	int       errors = 0;
	int       stall_cycles = 0;

	periodic_task_dispatcher_unit #(.MAX_TASKS(SLOTS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.task_handle(task_handle),
		.period(period),
		.phase_offset(phase_offset),
		.strobe(strobe),
		.result_kind(result_kind),
		.success(success),
		.fired_handle(fired_handle),
		.fired_slot(fired_slot),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		if (errors < 40)
			$display("%0t mismatch: %s", $time, msg);
		errors++;
	endtask

	// Updates the slot table and queues the results of one accepted command.
	function automatic void dispatch_cmd(input cmd_t c);
		int  fired;
		int  i;
		logic ok;
		fired = 0;
		ok = 1'b0;
		case (c.op)
			OP_TICK: begin
				for (i = 0; i < slots_filled && i < SLOTS; i++) begin
					if (slot_hnd[i] != '0) begin
						if (slot_cnt[i] == '0) begin
							pending_results.push_back(outcome_t'{KIND_FIRED, 1'b1,
								slot_hnd[i], 3'(i), 1'b0});
							fired++;
							slot_cnt[i] = slot_per[i] - 16'd1;
						end else begin
							slot_cnt[i] = slot_cnt[i] - 16'd1;
						end
					end
				end
				if (fired == 0)
					pending_results.push_back(outcome_t'{KIND_IDLE, 1'b1, 8'h00, 3'd0, 1'b0});
			end
			OP_CREATE: begin
				if (c.handle != '0 && slots_filled < SLOTS) begin
					slot_hnd[slots_filled] = c.handle;
					slot_per[slots_filled] = c.per;
					slot_cnt[slots_filled] = c.dly;
					slots_filled++;
					ok = 1'b1;
				end
			end
			OP_DELETE: begin
				// handle 0 hits the first empty slot, which changes nothing
				for (i = 0; i < SLOTS; i++) begin
					if (!ok && slot_hnd[i] == c.handle) begin
						slot_hnd[i] = '0;
						ok = 1'b1;
					end
				end
			end
			default: ;
		endcase
		if (c.op != OP_TICK)
			pending_results.push_back(outcome_t'{KIND_STATUS, ok, 8'h00, 3'd0, 1'b0});
		pending_results[pending_results.size() - 1].last = 1'b1;
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		int   roll;
		int   s;
		roll = $urandom_range(0, 99);
		c.handle = HANDLE_W'($urandom_range(0, 255));
		c.per = TIME_W'($urandom_range(0, 65535));
		c.dly = TIME_W'($urandom_range(0, 65535));
		if (roll < 70) begin
			c.op = OP_TICK;
		end else if (roll < 80) begin
			c.op = OP_CREATE;
		end else if (roll < 83) begin
			c.op = OP_DELETE;
			s = $urandom_range(0, SLOTS - 1);
			if (slot_hnd[s] != '0)
				c.handle = slot_hnd[s];
		end else if (roll < 92) begin
			c.op = OP_DELETE;
			if ($urandom_range(0, 3) == 0)
				c.handle = '0;
		end else begin
			c.op = OP_BAD;
		end
		return c;
	endfunction

	// Returns at the edge where the command transfers; start stays high.
	task automatic issue(input cmd_t c, input int idle_pct);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= c.op;
		task_handle <= c.handle;
		period <= c.per;
		phase_offset <= c.dly;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe === 1'b1) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("result with nothing pending");
			end else begin
				want = pending_results.pop_front();
				if (result_kind !== want.kind)
					flag_mismatch($sformatf("result_kind %0d, want %0d", result_kind, want.kind));
				if (success !== want.ok)
					flag_mismatch($sformatf("success %0b, want %0b", success, want.ok));
				if (fired_handle !== want.handle)
					flag_mismatch($sformatf("fired_handle %h, want %h", fired_handle, want.handle));
				if (fired_slot !== want.slot)
					flag_mismatch($sformatf("fired_slot %0d, want %0d", fired_slot, want.slot));
				if (last !== want.last)
					flag_mismatch($sformatf("last %0b, want %0b", last, want.last));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || strobe === 1'b1 || (start && busy === 1'b0)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	initial begin : main_seq
		cmd_t c;
		int   k;
		int   ph;
		int   pct;
		arst_n <= 1'b0;
		start <= 1'b0;
		opcode <= OP_TICK;
		task_handle <= '0;
		period <= '0;
		phase_offset <= '0;
		plan = '{
			'{'{OP_TICK,   8'h00, 16'h0000, 16'h0000}, 1'b1, KIND_IDLE,   1'b1},
			'{'{OP_CREATE, 8'h00, 16'h0005, 16'h0001}, 1'b1, KIND_STATUS, 1'b0},
			'{'{OP_DELETE, 8'h00, 16'h0000, 16'h0000}, 1'b1, KIND_STATUS, 1'b1},
			'{'{OP_DELETE, 8'h5A, 16'h0000, 16'h0000}, 1'b1, KIND_STATUS, 1'b0},
			'{'{OP_BAD,    8'hFF, 16'hFFFF, 16'hFFFF}, 1'b1, KIND_STATUS, 1'b0},
			'{'{OP_CREATE, 8'h01, 16'h0000, 16'h0000}, 1'b1, KIND_STATUS, 1'b1},
			'{'{OP_CREATE, 8'hFF, 16'hFFFF, 16'hFFFF}, 1'b1, KIND_STATUS, 1'b1},
			'{'{OP_CREATE, 8'h80, 16'h0001, 16'h0000}, 1'b1, KIND_STATUS, 1'b1},
			'{'{OP_CREATE, 8'h7F, 16'h0002, 16'h0001}, 1'b1, KIND_STATUS, 1'b1},
			'{'{OP_TICK,   8'h00, 16'h0000, 16'h0000}, 1'b0, KIND_STATUS, 1'b0},
			'{'{OP_TICK,   8'hA5, 16'h1234, 16'h4321}, 1'b0, KIND_STATUS, 1'b0},
			'{'{OP_CREATE, 8'h10, 16'h0001, 16'h0000}, 1'b1, KIND_STATUS, 1'b1},
			'{'{OP_CREATE, 8'h20, 16'h0001, 16'h0000}, 1'b1, KIND_STATUS, 1'b1},
			'{'{OP_CREATE, 8'h30, 16'h0003, 16'h0002}, 1'b1, KIND_STATUS, 1'b1},
			'{'{OP_CREATE, 8'h80, 16'h0004, 16'h0000}, 1'b1, KIND_STATUS, 1'b1},
			'{'{OP_CREATE, 8'h99, 16'h0001, 16'h0000}, 1'b1, KIND_STATUS, 1'b0},
			'{'{OP_TICK,   8'h00, 16'h0000, 16'h0000}, 1'b0, KIND_STATUS, 1'b0},
			'{'{OP_DELETE, 8'h80, 16'h0000, 16'h0000}, 1'b1, KIND_STATUS, 1'b1},
			'{'{OP_TICK,   8'h00, 16'h0000, 16'h0000}, 1'b0, KIND_STATUS, 1'b0},
			'{'{OP_DELETE, 8'h80, 16'h0000, 16'h0000}, 1'b1, KIND_STATUS, 1'b1},
			'{'{OP_DELETE, 8'h80, 16'h0000, 16'h0000}, 1'b1, KIND_STATUS, 1'b0},
			'{'{OP_DELETE, 8'h00, 16'h0000, 16'h0000}, 1'b1, KIND_STATUS, 1'b1},
			'{'{OP_CREATE, 8'h42, 16'h0001, 16'h0000}, 1'b1, KIND_STATUS, 1'b0},
			'{'{OP_TICK,   8'h00, 16'h0000, 16'h0000}, 1'b0, KIND_STATUS, 1'b0},
			'{'{OP_TICK,   8'h00, 16'h0000, 16'h0000}, 1'b0, KIND_STATUS, 1'b0}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < 25; k++) begin
			c = plan[k].cmd;
			issue(c, 0);
			dispatch_cmd(c);
			if (plan[k].typed) begin
				void'(pending_results.pop_back());
				pending_results.push_back(outcome_t'{plan[k].kind, plan[k].ok, 8'h00, 3'd0,
					1'b1});
			end
		end

		// sender phases: no gaps, heavy gaps, no gaps, light gaps
		for (ph = 0; ph < 4; ph++) begin
			pct = (ph == 1) ? 60 : (ph == 3) ? 20 : 0;
			drain();
			repeat (PHASE_ITEMS) begin
				c = random_cmd();
				issue(c, pct);
				dispatch_cmd(c);
			end
		end

		drain();
		repeat (SLOTS + 4) @(posedge clk);
		if (pending_results.size() != 0)
			flag_mismatch($sformatf("%0d results never came", pending_results.size()));
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
src/ptd_pkg.sv
src/ptd_slot_mem.sv
src/periodic_task_dispatcher_unit.sv
bench/tb_top.sv
